// ===== src/gcfp_pkg.sv =====
`default_nettype none

package gcfp_pkg;

  localparam int FRAME_MAX_LEN = 64;
  localparam int FL_W = $clog2(FRAME_MAX_LEN);

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [16:0] ACC_MAX = 17'h1FFFF;
  localparam logic [6:0]  CIF_MAX = 7'd127;

  localparam logic [2:0] FIELD_PAN   = 3'd2;
  localparam logic [2:0] FIELD_TILT  = 3'd3;
  localparam logic [2:0] FIELD_MODE  = 3'd4;
  localparam logic [2:0] FIELD_EXTRA = 3'd5;

  localparam logic [6:0] PREFIX_LEN = 7'd3;

  localparam logic [23:0] PREFIX_TEXT [2] = '{"$GM", "CMD"};
  localparam logic [39:0] MODE_TEXT [4] = '{"TRACK", "AIMED", "HOLD ", "STOP "};
  localparam logic [6:0]  MODE_LEN [4] = '{7'd5, 7'd5, 7'd4, 7'd4};

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_PENDING     = 3'd1,
    ST_FIELD_COUNT = 3'd2,
    ST_PREFIX      = 3'd3,
    ST_PAN         = 3'd4,
    ST_TILT        = 3'd5,
    ST_MODE        = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    REG_PAN_MIN  = 2'd0,
    REG_PAN_MAX  = 2'd1,
    REG_TILT_MIN = 2'd2,
    REG_TILT_MAX = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_TRACK = 2'd0,
    MODE_AIMED = 2'd1,
    MODE_HOLD  = 2'd2,
    MODE_STOP  = 2'd3
  } mode_t;

  typedef struct packed {
    logic [16:0] acc;
    logic        neg;
    logic        bad;
    logic        seen;
  } num_t;

  typedef struct packed {
    logic            collecting;
    logic            overflowed;
    logic [FL_W-1:0] frame_length;
    logic [2:0]      field_index;
    logic [6:0]      char_in_field;
    logic            prefix_ok;
    num_t            pan;
    num_t            tilt;
    logic [3:0]      mode_match;
  } gcfp_state_t;

  typedef struct packed {
    logic signed [15:0] pan_min;
    logic signed [15:0] pan_max;
    logic signed [15:0] tilt_min;
    logic signed [15:0] tilt_max;
  } gcfp_bounds_t;

  typedef struct packed {
    status_t            status;
    logic signed [15:0] pan_value;
    logic signed [15:0] tilt_value;
    mode_t              mode_code;
  } gcfp_result_t;

  function automatic logic [7:0] prefix_char(input logic f, input logic [1:0] i);
    logic [23:0] t;
    t = PREFIX_TEXT[f];
    case (i)
      2'd0:    prefix_char = t[23:16];
      2'd1:    prefix_char = t[15:8];
      2'd2:    prefix_char = t[7:0];
      default: prefix_char = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] mode_char(input logic [1:0] k, input logic [2:0] i);
    logic [39:0] t;
    t = MODE_TEXT[k];
    case (i)
      3'd0:    mode_char = t[39:32];
      3'd1:    mode_char = t[31:24];
      3'd2:    mode_char = t[23:16];
      3'd3:    mode_char = t[15:8];
      3'd4:    mode_char = t[7:0];
      default: mode_char = 8'h00;
    endcase
  endfunction

  // one character of a numeric field
  function automatic num_t num_step(input num_t n, input logic [7:0] c, input logic first);
    num_t        r;
    logic [20:0] v;
    r = n;
    v = '0;
    if (first && c == CH_MINUS) begin
      r.neg = 1'b1;
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      v = {4'b0, n.acc} * 21'd10 + {13'b0, 8'(c - CH_ZERO)};
      r.acc = (v > {4'b0, ACC_MAX}) ? ACC_MAX : v[16:0];
    end else begin
      r.bad = 1'b1;
    end
    r.seen = 1'b1;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/gcfp_ifs.sv =====
`default_nettype none

interface gcfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface gcfp_result_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic signed [15:0] pan_value;
  logic signed [15:0] tilt_value;
  logic [1:0]         mode_code;

  modport source (output valid, output status, output pan_value, output tilt_value,
                  output mode_code, input ready);
  modport sink (input valid, input status, input pan_value, input tilt_value,
                input mode_code, output ready);
endinterface

interface gcfp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/gimbal_command_frame_parser.sv =====
// Gimbal command frame parser: byte stream in, one status beat out per byte.
// rx: one received byte per beat (valid/ready). result: one beat per input
// byte carrying status, pan_value, tilt_value and mode_code; the values are
// nonzero only on a frame end with status ok. cfg: writes the pan/tilt bounds
// by index (0 pan_min, 1 pan_max, 2 tilt_min, 3 tilt_max); always ready, and
// meant to be written only while no byte is in flight.
// A byte passes an input register and then the field tracker and verdict
// logic into the result register. One byte per cycle is sustained while the
// receiver takes each result beat; the frame state is a single register
// updated once per byte as it moves into the result register.
// Reset clears the frame state, empties both registers and loads the bounds
// with the full signed 16-bit range.
// When the receiver stalls, the result register holds its beat, the input
// register takes one more byte, and then rx.ready drops until the result
// beat is taken.
`default_nettype none

module gimbal_command_frame_parser
  import gcfp_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst,
  gcfp_byte_if.sink    rx,
  gcfp_result_if.source result,
  gcfp_cfg_if.sink     cfg
);

  logic         a_valid;
  logic [7:0]   byte_r;
  logic         b_load;
  logic         res_valid;
  gcfp_result_t res_r;
  gcfp_result_t verdict;
  gcfp_bounds_t bounds;
  gcfp_state_t  st;
  gcfp_state_t  view;
  logic         frame_end;

  assign b_load = a_valid && (!res_valid || result.ready);
  assign rx.ready = !a_valid || b_load;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      a_valid <= 1'b1;
    end else if (b_load) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) byte_r <= rx.rx_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bounds.pan_min <= 16'sh8000;
      bounds.pan_max <= 16'sh7FFF;
      bounds.tilt_min <= 16'sh8000;
      bounds.tilt_max <= 16'sh7FFF;
    end else if (cfg.valid) begin
      unique case (reg_idx_t'(cfg.index))
        REG_PAN_MIN:  bounds.pan_min <= cfg.data;
        REG_PAN_MAX:  bounds.pan_max <= cfg.data;
        REG_TILT_MIN: bounds.tilt_min <= cfg.data;
        REG_TILT_MAX: bounds.tilt_max <= cfg.data;
        default:      bounds <= bounds;
      endcase
    end
  end

  gcfp_field_track u_track (
    .clk       (clk),
    .rst       (rst),
    .advance   (b_load),
    .byte_in   (byte_r),
    .st        (st),
    .view      (view),
    .frame_end (frame_end)
  );

  gcfp_verdict u_verdict (
    .view      (view),
    .frame_end (frame_end),
    .bounds    (bounds),
    .result    (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (b_load) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_load) res_r <= verdict;
  end

  assign result.valid = res_valid;
  assign result.status = res_r.status;
  assign result.pan_value = res_r.pan_value;
  assign result.tilt_value = res_r.tilt_value;
  assign result.mode_code = res_r.mode_code;

  // a held input byte must not be overwritten
  a_hold: assert property (@(posedge clk) disable iff (rst)
    a_valid && !b_load |=> a_valid && $stable(byte_r))
    else $error("input byte lost while waiting");

  // a byte outside a frame that does not open one reports pending
  a_idle: assert property (@(posedge clk) disable iff (rst)
    b_load && !st.collecting && byte_r != CH_DOLLAR |=> result.status == ST_PENDING)
    else $error("idle byte gave a frame verdict");

  // an overflowed frame closes with a field count error
  a_ovf: assert property (@(posedge clk) disable iff (rst)
    b_load && st.collecting && st.overflowed && byte_r == CH_HASH
    |=> result.status == ST_FIELD_COUNT)
    else $error("overflowed frame not reported");

  // values are zero unless the frame passed every check
  a_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.status != ST_OK
    |-> result.pan_value == '0 && result.tilt_value == '0 && result.mode_code == '0)
    else $error("payload set on a failed beat");

endmodule

`default_nettype wire

// ===== src/gcfp_field_track.sv =====
`default_nettype none

module gcfp_field_track
  import gcfp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        advance,
  input  wire logic [7:0]  byte_in,
  output gcfp_state_t      st,
  output gcfp_state_t      view,
  output logic             frame_end
);

  gcfp_state_t st_next;

  always_comb begin
    view = st;
    frame_end = 1'b0;

    if (byte_in == CH_DOLLAR) begin
      view.collecting = 1'b1;
      view.overflowed = 1'b0;
      view.frame_length = '0;
      view.field_index = '0;
      view.char_in_field = '0;
      view.prefix_ok = 1'b1;
      view.pan = '0;
      view.tilt = '0;
      view.mode_match = 4'hF;
    end

    if (view.collecting && !view.overflowed) begin
      if (({1'b0, view.frame_length} + (FL_W+1)'(1)) < (FL_W+1)'(FRAME_MAX_LEN)) begin
        view.frame_length = view.frame_length + FL_W'(1);
        if (byte_in == CH_COMMA) begin
          if (view.field_index < FIELD_PAN && view.char_in_field != PREFIX_LEN)
            view.prefix_ok = 1'b0;
          if (view.field_index == FIELD_MODE) begin
            for (int k = 0; k < 4; k++)
              if (view.char_in_field != MODE_LEN[k]) view.mode_match[k] = 1'b0;
          end
          if (view.field_index < FIELD_EXTRA) view.field_index = view.field_index + 3'd1;
          view.char_in_field = '0;
        end else if (byte_in != CH_HASH && view.field_index != FIELD_EXTRA) begin
          if (view.field_index < FIELD_PAN) begin
            if (view.char_in_field >= PREFIX_LEN ||
                byte_in != prefix_char(view.field_index[0], view.char_in_field[1:0]))
              view.prefix_ok = 1'b0;
          end else if (view.field_index == FIELD_PAN) begin
            view.pan = num_step(view.pan, byte_in, view.char_in_field == '0);
          end else if (view.field_index == FIELD_TILT) begin
            view.tilt = num_step(view.tilt, byte_in, view.char_in_field == '0);
          end else begin
            for (int k = 0; k < 4; k++)
              if (view.char_in_field >= MODE_LEN[k] ||
                  byte_in != mode_char(2'(k), view.char_in_field[2:0]))
                view.mode_match[k] = 1'b0;
          end
          if (view.char_in_field != CIF_MAX) view.char_in_field = view.char_in_field + 7'd1;
        end
      end else begin
        view.overflowed = 1'b1;
      end
    end

    st_next = view;
    if (view.collecting && byte_in == CH_HASH) begin
      frame_end = 1'b1;
      st_next.collecting = 1'b0;
      st_next.frame_length = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/gcfp_verdict.sv =====
`default_nettype none

module gcfp_verdict
  import gcfp_pkg::*;
(
  input  wire gcfp_state_t  view,
  input  wire logic         frame_end,
  input  wire gcfp_bounds_t bounds,
  output gcfp_result_t      result
);

  logic [3:0]         mm;
  logic signed [17:0] pan_s;
  logic signed [17:0] tilt_s;
  logic               pan_out;
  logic               tilt_out;
  mode_t              code;

  always_comb begin
    mm = view.mode_match;
    if (view.field_index == FIELD_MODE) begin
      for (int k = 0; k < 4; k++)
        if (view.char_in_field != MODE_LEN[k]) mm[k] = 1'b0;
    end

    pan_s = view.pan.neg ? -$signed({1'b0, view.pan.acc}) : $signed({1'b0, view.pan.acc});
    tilt_s = view.tilt.neg ? -$signed({1'b0, view.tilt.acc})
                           : $signed({1'b0, view.tilt.acc});

    pan_out = pan_s < $signed({{2{bounds.pan_min[15]}}, bounds.pan_min}) ||
              pan_s > $signed({{2{bounds.pan_max[15]}}, bounds.pan_max});
    tilt_out = tilt_s < $signed({{2{bounds.tilt_min[15]}}, bounds.tilt_min}) ||
               tilt_s > $signed({{2{bounds.tilt_max[15]}}, bounds.tilt_max});

    // lowest matching mode wins
    if (mm[0])      code = MODE_TRACK;
    else if (mm[1]) code = MODE_AIMED;
    else if (mm[2]) code = MODE_HOLD;
    else            code = MODE_STOP;

    result = '0;
    result.status = ST_PENDING;
    if (frame_end) begin
      if (view.overflowed || view.field_index < FIELD_MODE)
        result.status = ST_FIELD_COUNT;
      else if (!view.prefix_ok)
        result.status = ST_PREFIX;
      else if (!view.pan.seen || view.pan.bad)
        result.status = ST_PAN;
      else if (!view.tilt.seen || view.tilt.bad)
        result.status = ST_TILT;
      else if (pan_out)
        result.status = ST_PAN;
      else if (tilt_out)
        result.status = ST_TILT;
      else if (mm == 4'h0)
        result.status = ST_MODE;
      else begin
        result.status = ST_OK;
        result.pan_value = pan_s[15:0];
        result.tilt_value = tilt_s[15:0];
        result.mode_code = code;
      end
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_gimbal_command_frame_parser.sv =====
`timescale 1ns / 100ps

module tb_gimbal_command_frame_parser;
  import gcfp_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int RANDOM_BYTES  = 880;
  localparam int PHASE_BYTES   = 140;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int MAG_LIMIT     = 131071;
  localparam int CHARS_LIMIT   = 127;

  logic clk = 1'b0;
  logic rst = 1'b1;

  gcfp_byte_if   rx_if ();
  gcfp_result_if res_if ();
  gcfp_cfg_if    cfg_if ();

  gimbal_command_frame_parser u_top (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx_if),
    .result (res_if),
    .cfg    (cfg_if)
  );

  always #CLK_HALF clk = ~clk;

  // frame tracker mirror
  bit                 fr_active, fr_long, fr_prefix_ok;
  int                 fr_len, fld, fld_chars;
  int                 num_mag [2];
  bit                 num_neg [2];
  bit                 num_bad [2];
  bit                 num_seen [2];
  bit [3:0]           mode_live;
  logic signed [15:0] lim_pan_min  = -16'sd32768;
  logic signed [15:0] lim_pan_max  = 16'sd32767;
  logic signed [15:0] lim_tilt_min = -16'sd32768;
  logic signed [15:0] lim_tilt_max = 16'sd32767;

  string prefix_word [2] = '{"$GM", "CMD"};
  string mode_word [4]   = '{"TRACK", "AIMED", "HOLD", "STOP"};

  gcfp_result_t verdict_q [$];

  bit steady;
  int n_sent, n_frames, n_checked, n_ok, n_settings, n_errors;
  int cycles;

  function automatic void drop_short_modes();
    for (int k = 0; k < 4; k++) begin
      if (fld_chars != mode_word[k].len()) mode_live[k] = 1'b0;
    end
  endfunction

  function automatic void end_field();
    if (fld < 2 && fld_chars != 3) fr_prefix_ok = 1'b0;
    if (fld == 4) drop_short_modes();
    if (fld < 5) fld++;
    fld_chars = 0;
  endfunction

  function automatic void take_char(input logic [7:0] c);
    int n, v;
    if (fld < 2) begin
      if (fld_chars >= 3 || c != 8'(prefix_word[fld].getc(fld_chars))) fr_prefix_ok = 1'b0;
    end else if (fld < 4) begin
      n = fld - 2;
      if (fld_chars == 0 && c == CH_MINUS) begin
        num_neg[n] = 1'b1;
      end else if (c >= CH_ZERO && c <= CH_NINE) begin
        v = num_mag[n] * 10 + (int'(c) - int'(CH_ZERO));
        num_mag[n] = (v > MAG_LIMIT) ? MAG_LIMIT : v;
      end else begin
        num_bad[n] = 1'b1;
      end
      num_seen[n] = 1'b1;
    end else if (fld == 4) begin
      for (int k = 0; k < 4; k++) begin
        if (fld_chars >= mode_word[k].len() || c != 8'(mode_word[k].getc(fld_chars)))
          mode_live[k] = 1'b0;
      end
    end else begin
      return;
    end
    if (fld_chars < CHARS_LIMIT) fld_chars++;
  endfunction

  // status beat that one received byte produces
  function automatic gcfp_result_t frame_verdict(input logic [7:0] b);
    gcfp_result_t r;
    int pan, tilt, code;
    r.status     = ST_PENDING;
    r.pan_value  = '0;
    r.tilt_value = '0;
    r.mode_code  = MODE_TRACK;
    if (b == CH_DOLLAR) begin
      fr_active    = 1'b1;
      fr_long      = 1'b0;
      fr_len       = 0;
      fld          = 0;
      fld_chars    = 0;
      fr_prefix_ok = 1'b1;
      mode_live    = 4'hF;
      for (int n = 0; n < 2; n++) begin
        num_mag[n]  = 0;
        num_neg[n]  = 1'b0;
        num_bad[n]  = 1'b0;
        num_seen[n] = 1'b0;
      end
    end
    if (!fr_active) return r;
    if (!fr_long) begin
      if (fr_len + 1 < FRAME_MAX_LEN) begin
        fr_len++;
        if (b == CH_COMMA) end_field();
        else if (b != CH_HASH) take_char(b);
      end else begin
        fr_long = 1'b1;
      end
    end
    if (b != CH_HASH) return r;

    fr_active = 1'b0;
    fr_len    = 0;
    if (fr_long || fld < 4) begin
      r.status = ST_FIELD_COUNT;
      return r;
    end
    if (fld == 4) drop_short_modes();
    if (!fr_prefix_ok) begin
      r.status = ST_PREFIX;
      return r;
    end
    if (!num_seen[0] || num_bad[0]) begin
      r.status = ST_PAN;
      return r;
    end
    if (!num_seen[1] || num_bad[1]) begin
      r.status = ST_TILT;
      return r;
    end
    pan  = num_neg[0] ? -num_mag[0] : num_mag[0];
    tilt = num_neg[1] ? -num_mag[1] : num_mag[1];
    if (pan < lim_pan_min || pan > lim_pan_max) begin
      r.status = ST_PAN;
      return r;
    end
    if (tilt < lim_tilt_min || tilt > lim_tilt_max) begin
      r.status = ST_TILT;
      return r;
    end
    if (mode_live == 4'h0) begin
      r.status = ST_MODE;
      return r;
    end
    code = 0;
    while (code < 3 && !mode_live[code]) code++;
    r.status     = ST_OK;
    r.pan_value  = 16'(pan);
    r.tilt_value = 16'(tilt);
    r.mode_code  = mode_t'(code);
    return r;
  endfunction

  // mirror config writes, predict accepted bytes, check result beats
  always @(posedge clk) begin : scoreboard
    gcfp_result_t e;
    if (!rst) begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (reg_idx_t'(cfg_if.index))
          REG_PAN_MIN:  lim_pan_min  = cfg_if.data;
          REG_PAN_MAX:  lim_pan_max  = cfg_if.data;
          REG_TILT_MIN: lim_tilt_min = cfg_if.data;
          REG_TILT_MAX: lim_tilt_max = cfg_if.data;
          default: ;
        endcase
      end
      if (rx_if.valid && rx_if.ready) verdict_q.push_back(frame_verdict(rx_if.rx_byte));
      if (res_if.valid && res_if.ready) begin
        if (verdict_q.size() == 0) begin
          $error("result beat with no status expected: status %0d", res_if.status);
          n_errors++;
        end else begin
          e = verdict_q.pop_front();
          n_checked++;
          if (res_if.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, res_if.status);
            n_errors++;
          end
          if (res_if.pan_value !== e.pan_value) begin
            $error("pan_value: expected %0d, got %0d", e.pan_value, res_if.pan_value);
            n_errors++;
          end
          if (res_if.tilt_value !== e.tilt_value) begin
            $error("tilt_value: expected %0d, got %0d", e.tilt_value, res_if.tilt_value);
            n_errors++;
          end
          if (res_if.mode_code !== e.mode_code) begin
            $error("mode_code: expected %0d, got %0d", e.mode_code, res_if.mode_code);
            n_errors++;
          end
          if (e.status == ST_OK) n_ok++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d status beats outstanding", cycles,
               verdict_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int draw_wait();
    if (steady) return 0;
    return $urandom_range(0, 13);
  endfunction

  // receiver with random stalls
  initial begin
    int w;
    res_if.ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      w = draw_wait();
      if (w > 0) begin
        @(negedge clk);
        res_if.ready <= 1'b0;
        repeat (w - 1) @(negedge clk);
      end
      @(negedge clk);
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!(res_if.valid && res_if.ready));
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int w;
    w = draw_wait();
    if (w > 0) begin
      @(negedge clk);
      rx_if.valid <= 1'b0;
      repeat (w - 1) @(negedge clk);
    end
    @(negedge clk);
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk); while (!(rx_if.valid && rx_if.ready));
    n_sent++;
  endtask

  // mut_pct: chance per byte of swapping in a random byte
  task automatic send_text(input string s, input int mut_pct);
    logic [7:0] b;
    for (int i = 0; i < s.len(); i++) begin
      b = 8'(s.getc(i));
      if (int'($urandom_range(0, 99)) < mut_pct) b = 8'($urandom_range(0, 255));
      send_byte(b);
    end
  endtask

  task automatic settle();
    @(negedge clk);
    rx_if.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input reg_idx_t idx, input int val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= 16'(val);
    do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_limits(input int pmin, input int pmax, input int tmin, input int tmax);
    settle();
    write_limit(REG_PAN_MIN, pmin);
    write_limit(REG_PAN_MAX, pmax);
    write_limit(REG_TILT_MIN, tmin);
    write_limit(REG_TILT_MAX, tmax);
    n_settings++;
  endtask

  function automatic string junk_text(input int n);
    string s;
    int c;
    s = "";
    for (int i = 0; i < n; i++) begin
      do c = $urandom_range(32, 126); while (c == int'(CH_DOLLAR) || c == int'(CH_HASH));
      s = $sformatf("%s%c", s, c);
    end
    return s;
  endfunction

  // mostly values around the bounds, some malformed or oversized numbers
  function automatic string number_text(input int lo, input int hi);
    int a, b, v, r;
    r = $urandom_range(0, 99);
    a = (lo < hi) ? lo : hi;
    b = (lo < hi) ? hi : lo;
    if (r < 60) begin
      v = a + int'($urandom_range(0, b - a));
    end else if (r < 80) begin
      v = ($urandom_range(0, 1) ? lo : hi) + int'($urandom_range(0, 4)) - 2;
    end else if (r < 88) begin
      v = $urandom_range(0, 140000);
      if ($urandom_range(0, 1)) v = -v;
    end else if (r < 91) begin
      return "-";
    end else if (r < 93) begin
      return "";
    end else if (r < 95) begin
      return "-0";
    end else if (r < 97) begin
      return $sformatf("00%0d", $urandom_range(0, 999));
    end else if (r < 98) begin
      return $sformatf("%0d-%0d", $urandom_range(0, 99), $urandom_range(0, 99));
    end else begin
      return $sformatf("%0d%0d", $urandom_range(1, 9999), $urandom_range(100000, 999999));
    end
    return $sformatf("%0d", v);
  endfunction

  function automatic string mode_text();
    case ($urandom_range(0, 15))
      0, 1, 2:  return "TRACK";
      3, 4, 5:  return "AIMED";
      6, 7, 8:  return "HOLD";
      9, 10, 11: return "STOP";
      12:       return "TRAC";
      13:       return "STOPS";
      14:       return "hold";
      default:  return "";
    endcase
  endfunction

  task automatic random_frame();
    string s;
    int r, mut;
    if ($urandom_range(0, 99) < 88) begin
      s = "$GM,CMD";
    end else begin
      case ($urandom_range(0, 4))
        0:       s = "$GX,CMD";
        1:       s = "$GM,CM";
        2:       s = "$GMM,CMD";
        3:       s = "$GM,cmd";
        default: s = "$,CMD";
      endcase
    end
    s = {s, ",", number_text(lim_pan_min, lim_pan_max), ",",
         number_text(lim_tilt_min, lim_tilt_max)};
    if ($urandom_range(0, 99) >= 4) s = {s, ",", mode_text()};
    r = $urandom_range(0, 99);
    if (r < 8) s = {s, ",", junk_text($urandom_range(0, 12))};
    else if (r < 11) s = {s, ",", junk_text($urandom_range(35, 55))};
    mut = ($urandom_range(0, 9) == 0) ? 4 : 0;
    if ($urandom_range(0, 99) < 4) send_text(s, mut);
    else send_text({s, "#"}, mut);
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
    end
    n_frames++;
  endtask

  task automatic send_frame(input string s);
    send_text(s, 0);
    n_frames++;
  endtask

  task automatic test_idle_bytes();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CH_HASH);
    send_byte(CH_COMMA);
    send_frame("$#");
  endtask

  task automatic test_number_fields();
    send_frame("$GM,CMD,-32768,32767,TRACK#");
    send_frame("$GM,CMD,32767,-32768,AIMED#");
    send_frame("$GM,CMD,0,-,HOLD#");
    send_frame("$GM,CMD,,5,STOP#");
    send_frame("$GM,CMD,5,1x,STOP#");
    send_frame("$GM,CMD,1-2,3,STOP#");
    send_frame("$GM,CMD,99999999,0,HOLD#");
    send_frame("$GM,CMD,0,-32769,HOLD#");
  endtask

  task automatic test_prefix_and_mode();
    send_frame("$GX,CMD,1,2,STOP#");
    send_frame("$GM,CMDD,1,2,STOP#");
    send_frame("$GM,CMD,1,2,TRAC#");
    send_frame("$GM,CMD,1,2,TRACKX#");
    send_frame("$GM,CMD,1,2,#");
    send_frame("$GM,CMD,1,2#");
    send_frame("$GM,CMD,1,2,TRACK,extra,text#");
    // a zero byte is just another character
    send_text("$GM,CMD,1,2,HO", 0);
    send_byte(8'h00);
    send_frame("LD#");
    // restart in the middle of a frame
    send_frame("$GM,CM$GM,CMD,3,4,HOLD#");
  endtask

  task automatic test_frame_length();
    string pad;
    steady = 1'b1;
    // 63 bytes still fit, 64 overflow
    pad = junk_text(45);
    send_frame({"$GM,CMD,1,2,STOP,", pad, "#"});
    pad = junk_text(46);
    send_frame({"$GM,CMD,1,2,STOP,", pad, "#"});
    send_frame({"$GM,CMD,1,2,STOP,", junk_text(80), "#"});
    steady = 1'b0;
  endtask

  task automatic test_bounds();
    set_limits(0, 0, -1, -1);
    send_frame("$GM,CMD,0,-1,STOP#");
    send_frame("$GM,CMD,-1,-1,STOP#");
    send_frame("$GM,CMD,0,0,STOP#");
    // crossed bounds reject everything
    set_limits(1, -1, 32767, -32768);
    send_frame("$GM,CMD,0,0,HOLD#");
    set_limits(-32768, 32767, 1, -1);
    send_frame("$GM,CMD,0,0,HOLD#");
    set_limits(-32768, 32767, -32768, 32767);
    send_frame("$GM,CMD,-32768,32767,AIMED#");
  endtask

  task automatic test_random_stream();
    int start, mark, phase, lo, hi;
    start = n_sent;
    phase = 0;
    while (n_sent - start < RANDOM_BYTES) begin
      case (phase % 6)
        0: set_limits(-32768, 32767, -32768, 32767);
        1: begin
          lo = int'($signed(16'($urandom_range(0, 65535))));
          set_limits(0, 0, lo, lo);
        end
        2: set_limits(100, -100, -32768, 32767);
        3: begin
          lo = int'($signed(16'($urandom_range(0, 65535))));
          hi = lo + int'($urandom_range(0, 2000));
          if (hi > 32767) hi = 32767;
          set_limits(lo, hi, -hi, -lo > 32767 ? 32767 : -lo);
        end
        4: set_limits(int'($signed(16'($urandom_range(0, 65535)))),
                      int'($signed(16'($urandom_range(0, 65535)))),
                      int'($signed(16'($urandom_range(0, 65535)))),
                      int'($signed(16'($urandom_range(0, 65535)))));
        default: set_limits(0, int'($urandom_range(0, 32767)), 32767, -32768);
      endcase
      steady = ($urandom_range(0, 3) == 0);
      mark = n_sent;
      while (n_sent - mark < PHASE_BYTES) random_frame();
      phase++;
    end
    steady = 1'b0;
  endtask

  initial begin
    rx_if.valid    = 1'b0;
    rx_if.rx_byte  = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = REG_PAN_MIN;
    cfg_if.data    = '0;
    steady         = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_idle_bytes();
    test_number_fields();
    test_prefix_and_mode();
    test_frame_length();
    test_bounds();
    test_random_stream();

    settle();
    if (verdict_q.size() != 0) begin
      $error("%0d status beats never arrived", verdict_q.size());
      n_errors++;
    end
    $display("sent %0d bytes in %0d frames across %0d bound settings", n_sent, n_frames,
             n_settings);
    $display("checked %0d status beats, %0d of them complete valid commands", n_checked, n_ok);
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
